/* hdl/tvd_superbee_advection_update_defines.svh */
// Assertion macros used by the RTL of the superbee advection update block.
`ifndef TVD_SUPERBEE_ADVECTION_UPDATE_DEFINES_SVH
`define TVD_SUPERBEE_ADVECTION_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TVDSB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tvdsb assertion failed");
`define TVDSB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tvdsb assertion failed");
`else
`define TVDSB_ASSERT(label, prop)
`define TVDSB_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* hdl/tvdsb_pkg.sv */
`default_nettype none

package tvdsb_pkg;

    // Integer bits of a slope ratio; the ratio saturates at +-4.
    localparam int unsigned RATIO_INT_BITS = 2;

endpackage

`default_nettype wire

/* hdl/tvdsb_ratio.sv */
`default_nettype none

module tvdsb_ratio #(
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  wire logic                                                  clk,
    input  wire logic signed [SAMPLE_BITS+1:0]                         num,
    input  wire logic signed [SAMPLE_BITS+1:0]                         den,
    output logic signed [FRAC_BITS+tvdsb_pkg::RATIO_INT_BITS+1:0]      ratio
);
    import tvdsb_pkg::*;

    localparam int unsigned MW = SAMPLE_BITS + 2;
    localparam int unsigned QB = FRAC_BITS + RATIO_INT_BITS;
    localparam int unsigned RW = MW + FRAC_BITS;
    localparam int unsigned CW = MW + FRAC_BITS + 2;
    localparam int unsigned OW = FRAC_BITS + RATIO_INT_BITS + 2;
    localparam logic signed [OW-1:0] LIM = OW'(64'd4 << FRAC_BITS);

    logic [MW-1:0] an, ad;

    // Stage 0 holds the prepared operands; stage i+1 has one more quotient bit.
    logic [RW-1:0] rem_reg  [QB+1];
    logic [MW-1:0] ad_reg   [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic          neg_reg  [QB+1];
    logic          zero_reg [QB+1];
    logic          sat_reg  [QB+1];

    logic [CW-1:0] shd  [QB];
    logic [CW-1:0] diff [QB];
    logic          ge   [QB];

    assign an = num[MW-1] ? MW'(-num) : MW'(num);
    assign ad = den[MW-1] ? MW'(-den) : MW'(den);

    always_comb
    begin
        for (int i = 0; i < QB; i++)
        begin
            shd[i]  = CW'(ad_reg[i]) << (QB - 1 - i);
            diff[i] = CW'(rem_reg[i]) - shd[i];
            ge[i]   = CW'(rem_reg[i]) >= shd[i];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= RW'(an) << FRAC_BITS;
        ad_reg[0]   <= ad;
        q_reg[0]    <= '0;
        neg_reg[0]  <= num[MW-1] ^ den[MW-1];
        zero_reg[0] <= (an == '0);
        sat_reg[0]  <= (ad == '0) || ({2'b00, an} >= {ad, 2'b00});
        for (int i = 0; i < QB; i++)
        begin
            rem_reg[i+1]  <= ge[i] ? RW'(diff[i]) : rem_reg[i];
            ad_reg[i+1]   <= ad_reg[i];
            q_reg[i+1]    <= {q_reg[i][QB-2:0], ge[i]};
            neg_reg[i+1]  <= neg_reg[i];
            zero_reg[i+1] <= zero_reg[i];
            sat_reg[i+1]  <= sat_reg[i];
        end
    end

    always_comb
    begin
        if (zero_reg[QB])
            ratio = '0;
        else if (sat_reg[QB])
            ratio = neg_reg[QB] ? -LIM : LIM;
        else
            ratio = neg_reg[QB] ? -OW'(q_reg[QB]) : OW'(q_reg[QB]);
    end

endmodule

`default_nettype wire

/* hdl/tvd_superbee_advection_update.sv */
// Superbee-limited TVD advection increment, one stencil point per item.
// Command channel: an item (courant and four upwind-ordered samples) is
// taken at each rising edge where start is high. busy stays low, so a new
// item may enter in every cycle; there is no other flow control.
// Result channel: done pulses for one cycle with increment valid in that
// cycle. The receiver has no way to hold results off and must take them.
// Throughput is one item per cycle. An item passes through the two
// slope-ratio dividers, which resolve one quotient bit per pipeline stage
// (FRAC_BITS + 2 stages), and through the input, operand preparation,
// limiter/gain, face scaling, face sum, Courant scaling and output
// saturation stages.
// Reset clears the valid bits of every stage; items in flight are dropped
// and no done pulse appears until a new item has passed through.
// The block keeps no state between items.
`default_nettype none

`include "tvd_superbee_advection_update_defines.svh"

module tvd_superbee_advection_update #(
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic        [FRAC_BITS:0]     courant,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_far_back,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_back,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_centre,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_ahead,
    output logic                               done,
    output logic signed [SAMPLE_BITS-1:0]      increment
);
    import tvdsb_pkg::*;

    localparam int unsigned SB  = SAMPLE_BITS;
    localparam int unsigned FB  = FRAC_BITS;
    localparam int unsigned CB  = FB + 1;
    localparam int unsigned DFW = SB + 1;
    localparam int unsigned DW  = SB + 2;
    localparam int unsigned OW  = FB + RATIO_INT_BITS + 2;
    localparam int unsigned SW  = OW + 1;
    localparam int unsigned PW  = FB + 2;
    localparam int unsigned GW  = FB + 1;
    localparam int unsigned GPW = PW + CB;
    localparam int unsigned MPW = DFW + GW;
    localparam int unsigned FW  = SB + 3;
    localparam int unsigned CPW = FW + CB;
    localparam int unsigned L   = FB + RATIO_INT_BITS + 1;
    localparam int unsigned LAT = FB + 9;

    localparam logic [CB-1:0]        ONE_C = CB'(64'd1 << FB);
    localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << FB);
    localparam logic signed [SW-1:0] TWO_S = SW'(64'd2 << FB);
    localparam logic signed [OW-1:0] LIM_R = OW'(64'd4 << FB);
    localparam logic signed [FW:0]   HI_L  = (FW+1)'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [FW:0]   LO_L  = -HI_L - (FW+1)'(1);
    localparam logic signed [DW-1:0] ONE_D = DW'(1);

    // Input stage.
    logic                  v0_reg;
    logic [CB-1:0]         c0_reg;
    logic signed [DFW-1:0] db0_reg, dm0_reg, da0_reg;

    // Side data delayed alongside the dividers.
    logic                  v_dly_reg  [L];
    logic [CB-1:0]         c_dly_reg  [L];
    logic signed [DFW-1:0] dm_dly_reg [L];
    logic signed [DFW-1:0] da_dly_reg [L];

    logic signed [OW-1:0] rn, rp;

    // Limiter and gain stage.
    logic                  vg_reg;
    logic [CB-1:0]         cg_reg;
    logic signed [DFW-1:0] dmg_reg, dag_reg;
    logic [GW-1:0]         gn_reg, gp_reg;

    // Face scaling stage.
    logic                  vm_reg;
    logic [CB-1:0]         cm_reg;
    logic signed [DFW-1:0] dmm_reg;
    logic [DFW-1:0]        mn_reg, mp_reg;
    logic                  nn_reg, np_reg;

    // Face sum stage.
    logic                 vf_reg;
    logic [CB-1:0]        cf_reg;
    logic signed [FW-1:0] face_reg;

    // Courant scaling stage.
    logic          vc_reg;
    logic [FW-1:0] mc_reg;
    logic          fneg_reg;

    // Output stage.
    logic                 done_reg;
    logic signed [SB-1:0] inc_reg;

    logic [GW-1:0]         gn_next, gp_next;
    logic [DFW-1:0]        mag_da, mag_dm;
    logic [FW-1:0]         mag_face;
    logic signed [FW-1:0]  face_next;
    logic signed [FW:0]    inc_wide;
    logic [CB-1:0]         omc;

    function automatic logic [PW-1:0] superbee(input logic signed [OW-1:0] r);
        logic signed [SW-1:0] rr, r2, a, b, m;
        rr = SW'(r);
        r2 = rr <<< 1;
        a  = (r2 < ONE_S) ? r2 : ONE_S;
        b  = (rr < TWO_S) ? rr : TWO_S;
        m  = (a > b) ? a : b;
        return (m > 0) ? PW'(m) : '0;
    endfunction

    tvdsb_ratio #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ratio_next (
        .clk  (clk),
        .num  (DW'(dm0_reg) + ONE_D),
        .den  (DW'(da0_reg) + ONE_D),
        .ratio(rn)
    );

    tvdsb_ratio #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ratio_prev (
        .clk  (clk),
        .num  (DW'(db0_reg) + ONE_D),
        .den  (DW'(dm0_reg) + ONE_D),
        .ratio(rp)
    );

    assign busy = 1'b0;

    assign omc = ONE_C - c_dly_reg[L-1];

    always_comb
    begin
        gn_next = GW'((GPW'(superbee(rn)) * GPW'(omc)) >> (FB + 1));
        gp_next = GW'((GPW'(superbee(rp)) * GPW'(omc)) >> (FB + 1));
        mag_da  = dag_reg[DFW-1] ? DFW'(-dag_reg) : DFW'(dag_reg);
        mag_dm  = dmg_reg[DFW-1] ? DFW'(-dmg_reg) : DFW'(dmg_reg);
        face_next = FW'(dmm_reg)
                  + (nn_reg ? -signed'(FW'(mn_reg)) : signed'(FW'(mn_reg)))
                  - (np_reg ? -signed'(FW'(mp_reg)) : signed'(FW'(mp_reg)));
        mag_face = face_reg[FW-1] ? FW'(-face_reg) : FW'(face_reg);
        // The increment is minus the scaled face difference.
        inc_wide = fneg_reg ? signed'((FW+1)'(mc_reg)) : -signed'((FW+1)'(mc_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < L; i++)
            begin
                v_dly_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v0_reg       <= start && !busy;
            v_dly_reg[0] <= v0_reg;
            for (int i = 1; i < L; i++)
            begin
                v_dly_reg[i] <= v_dly_reg[i-1];
            end
            vg_reg   <= v_dly_reg[L-1];
            vm_reg   <= vg_reg;
            vf_reg   <= vm_reg;
            vc_reg   <= vf_reg;
            done_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg  <= (courant > ONE_C) ? ONE_C : courant;
        db0_reg <= DFW'(sample_back)   - DFW'(sample_far_back);
        dm0_reg <= DFW'(sample_centre) - DFW'(sample_back);
        da0_reg <= DFW'(sample_ahead)  - DFW'(sample_centre);

        c_dly_reg[0]  <= c0_reg;
        dm_dly_reg[0] <= dm0_reg;
        da_dly_reg[0] <= da0_reg;
        for (int i = 1; i < L; i++)
        begin
            c_dly_reg[i]  <= c_dly_reg[i-1];
            dm_dly_reg[i] <= dm_dly_reg[i-1];
            da_dly_reg[i] <= da_dly_reg[i-1];
        end

        cg_reg  <= c_dly_reg[L-1];
        dmg_reg <= dm_dly_reg[L-1];
        dag_reg <= da_dly_reg[L-1];
        gn_reg  <= gn_next;
        gp_reg  <= gp_next;

        cm_reg  <= cg_reg;
        dmm_reg <= dmg_reg;
        mn_reg  <= DFW'((MPW'(mag_da) * MPW'(gn_reg)) >> FB);
        mp_reg  <= DFW'((MPW'(mag_dm) * MPW'(gp_reg)) >> FB);
        nn_reg  <= dag_reg[DFW-1];
        np_reg  <= dmg_reg[DFW-1];

        cf_reg   <= cm_reg;
        face_reg <= face_next;

        mc_reg   <= FW'((CPW'(mag_face) * CPW'(cf_reg)) >> FB);
        fneg_reg <= face_reg[FW-1];

        if (inc_wide > HI_L)
            inc_reg <= SB'(HI_L);
        else if (inc_wide < LO_L)
            inc_reg <= SB'(LO_L);
        else
            inc_reg <= SB'(inc_wide);
    end

    assign done      = done_reg;
    assign increment = inc_reg;

    `TVDSB_ASSERT(a_done_follows_start, done |-> $past(start, LAT))
    `TVDSB_ASSERT(a_ratio_bounded_n, v_dly_reg[L-1] |-> (rn <= LIM_R && rn >= -LIM_R))
    `TVDSB_ASSERT(a_ratio_bounded_p, v_dly_reg[L-1] |-> (rp <= LIM_R && rp >= -LIM_R))
    `TVDSB_ASSERT(a_gain_bounded, vg_reg |-> (gn_reg <= GW'(ONE_C) && gp_reg <= GW'(ONE_C)))
    `TVDSB_ASSERT(a_courant_scale_shrinks, vc_reg |-> (mc_reg <= $past(mag_face)))
    `TVDSB_ASSERT_ALWAYS(a_no_done_in_reset, !rst_n |-> !done)

endmodule

`default_nettype wire
